/* hdl/bds_pkg.sv */
// Package for the ARGB box downsampler: widths, register indexes, the
// structs passed between the core and its averaging unit, and the reciprocal table.
// No dependencies.
`default_nettype none

package bds_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 4096;
	localparam int unsigned MAX_BLOCK     = 16;

	localparam int unsigned BS_W      = 5;
	localparam int unsigned DIM_W     = 13;
	localparam int unsigned OFF_W     = 4;
	localparam int unsigned COORD_W   = 12;
	localparam int unsigned PIX_W     = 32;
	localparam int unsigned CH_W      = 8;
	localparam int unsigned SUM_W     = 16;
	localparam int unsigned LANES     = 4;
	localparam int unsigned RECIP_W   = 17;
	localparam int unsigned N_W       = 9;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

	localparam logic [BS_W-1:0]  BLOCK_SIZE_RST   = 5'd2;
	localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} tag_t;

	typedef struct packed {
		logic                     valid;
		logic [LANES*SUM_W-1:0]   sums;
		tag_t                     tag;
	} avg_req_t;

	typedef struct packed {
		logic                     valid;
		logic [PIX_W-1:0]         pixel;
		tag_t                     tag;
	} avg_res_t;

	// floor(65536 / (bs * bs)); the product with a sum is never more than one low.
	function automatic logic [RECIP_W-1:0] recip(input logic [BS_W-1:0] bs);
		logic [RECIP_W-1:0] m;
		case (bs)
			5'd2:    m = 17'd16384;
			5'd3:    m = 17'd7281;
			5'd4:    m = 17'd4096;
			5'd5:    m = 17'd2621;
			5'd6:    m = 17'd1820;
			5'd7:    m = 17'd1337;
			5'd8:    m = 17'd1024;
			5'd9:    m = 17'd809;
			5'd10:   m = 17'd655;
			5'd11:   m = 17'd541;
			5'd12:   m = 17'd455;
			5'd13:   m = 17'd387;
			5'd14:   m = 17'd334;
			5'd15:   m = 17'd291;
			5'd16:   m = 17'd256;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* hdl/bds_if.sv */
// Handshake interfaces of the ARGB box downsampler: pixel input and block output.
// Depends on bds_pkg.
`default_nettype none

interface bds_pix_if;
	import bds_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] in_pixel;

	modport source (output valid, output in_pixel, input ready);
	modport sink (input valid, input in_pixel, output ready);
endinterface

interface bds_blk_if;
	import bds_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   out_pixel;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;

	modport source (output valid, output out_pixel, output out_col, output out_row,
		input ready);
	modport sink (input valid, input out_pixel, input out_col, input out_row,
		output ready);
endinterface

`default_nettype wire

/* hdl/bds_avg.sv */
// Two-stage averaging unit: divides four channel sums by block_size squared
// through a reciprocal multiply and one correction step. Depends on bds_pkg.
`default_nettype none

module bds_avg (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic [bds_pkg::BS_W-1:0] bs,
	input  wire bds_pkg::avg_req_t      req,
	output bds_pkg::avg_res_t           res
);
	import bds_pkg::*;

	logic                     v_s2;
	logic [LANES*SUM_W-1:0]   sums_s2;
	tag_t                     tag_s2;
	logic                     v_s3;
	logic [LANES*SUM_W-1:0]   sums_s3;
	logic [LANES*CH_W-1:0]    q0_s3;
	tag_t                     tag_s3;

	logic [RECIP_W-1:0]       m;
	logic [N_W-1:0]           n;
	logic [LANES*CH_W-1:0]    q0_d;
	logic [LANES*CH_W-1:0]    q_d;

	assign m = recip(bs);
	assign n = N_W'(bs) * N_W'(bs);

	// Estimate: the quotient or one less.
	always_comb begin
		logic [SUM_W+RECIP_W-1:0] prod;
		for (int c = 0; c < LANES; c++) begin
			prod = (SUM_W+RECIP_W)'(sums_s2[c*SUM_W +: SUM_W]) * (SUM_W+RECIP_W)'(m);
			q0_d[c*CH_W +: CH_W] = prod[SUM_W +: CH_W];
		end
	end

	// Correction: the remainder is below twice n, so one compare settles it.
	always_comb begin
		logic [SUM_W-1:0] qn;
		logic [SUM_W-1:0] rem;
		for (int c = 0; c < LANES; c++) begin
			qn  = SUM_W'(q0_s3[c*CH_W +: CH_W]) * SUM_W'(n);
			rem = sums_s3[c*SUM_W +: SUM_W] - qn;
			q_d[c*CH_W +: CH_W] = q0_s3[c*CH_W +: CH_W] + CH_W'(rem >= SUM_W'(n));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= req.valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sums_s2 <= req.sums;
			tag_s2  <= req.tag;
			sums_s3 <= sums_s2;
			q0_s3   <= q0_d;
			tag_s3  <= tag_s2;
		end
	end

	assign res = '{valid: v_s3, pixel: q_d, tag: tag_s3};

endmodule

`default_nettype wire

/* hdl/box_downsample_argb_core.sv */
// Top level of the ARGB box downsampler: frame counters, column-sum memory
// with read-modify-write, output register. Depends on bds_pkg, bds_if, bds_avg.
//
//  channel   | modport          | payload                        | moves on
//  ----------+------------------+--------------------------------+------------------
//  pixels    | bds_pix_if.sink  | in_pixel                       | valid && ready
//  blocks    | bds_blk_if.source| out_pixel, out_col, out_row    | valid && ready
//  cfg       | plain write port | cfg_index, cfg_data            | cfg_we
//
// One pixel transaction is taken per cycle while pixels are not held off. A
// block's average reaches the output register through the memory read at the edge
// that takes its last pixel, then sum update and write-back, reciprocal
// multiply and correction. The column-sum memory is not cleared after reset;
// the first pixel of every block loads its entry instead of adding to it. Reset
// clears the frame counters and loads the register defaults.
// Pixels are held off only while a finished block waits in the output register
// and the next block has reached the last divide stage.
`default_nettype none

module box_downsample_argb_core #(
	parameter int unsigned MAX_WIDTH = bds_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bds_pkg::DIM_W-1:0]    cfg_data,
	bds_pix_if.sink                           pixels,
	bds_blk_if.source                         blocks
);
	import bds_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned XW = AW + 1;

	// Configuration registers.
	logic [BS_W-1:0]  block_size_q;
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;

	// Frame position.
	logic [OFF_W-1:0] off_x_q, off_y_q;
	logic [XW-1:0]    block_col_q, block_row_q;
	logic [XW-1:0]    pixel_col_q, pixel_row_q;

	// Effective register values after clamping.
	logic [BS_W-1:0]  bs_eff;
	logic [XW-1:0]    w_eff, h_eff;

	logic             restart;
	logic             acc;
	logic             adv;
	logic             in_range;
	logic             emit;

	// Column-sum memory, four 16-bit channel sums per block column.
	logic [LANES*SUM_W-1:0] mem [MAX_WIDTH];
	logic [LANES*SUM_W-1:0] rd_q;

	// Sum update stage.
	logic                   v1_s1;
	logic [AW-1:0]          addr_s1;
	logic                   fresh_s1;
	logic                   emit_s1;
	logic [PIX_W-1:0]       pixel_s1;
	tag_t                   tag_s1;
	logic                   byp_s1;
	logic [LANES*SUM_W-1:0] byp_data_s1;
	logic [LANES*SUM_W-1:0] wdata;

	avg_req_t               req;
	avg_res_t               res;

	// Output register.
	logic                   out_valid_q;
	logic [PIX_W-1:0]       out_pixel_q;
	tag_t                   out_tag_q;

	// ------------------------------------------------------------------
	// Configuration. Any write to a known register restarts the frame.
	// ------------------------------------------------------------------
	assign restart = cfg_we &&
		(cfg_index inside {CFG_BLOCK_SIZE, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= BLOCK_SIZE_RST;
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_SIZE:   block_size_q   <= cfg_data[BS_W-1:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero register acts as one; values above the limits act as the limit.
	always_comb begin
		if (block_size_q == '0)
			bs_eff = BS_W'(1);
		else if (32'(block_size_q) > 32'(MAX_BLOCK))
			bs_eff = BS_W'(MAX_BLOCK);
		else
			bs_eff = block_size_q;

		if (image_width_q == '0)
			w_eff = XW'(1);
		else if (32'(image_width_q) > 32'(MAX_WIDTH))
			w_eff = XW'(MAX_WIDTH);
		else
			w_eff = XW'(image_width_q);

		if (image_height_q == '0)
			h_eff = XW'(1);
		else if (32'(image_height_q) > 32'(MAX_WIDTH))
			h_eff = XW'(MAX_WIDTH);
		else
			h_eff = XW'(image_height_q);
	end

	// ------------------------------------------------------------------
	// Handshake. The pipeline moves unless a result would be pushed into a
	// full, stalled output register.
	// ------------------------------------------------------------------
	assign adv          = !(res.valid && out_valid_q && !blocks.ready);
	assign pixels.ready = adv;
	assign acc          = pixels.valid && adv;

	// ------------------------------------------------------------------
	// Frame counters. A block belongs to the output only if it fits entirely
	// inside the image; pixels of cut-off blocks are counted but not summed.
	// ------------------------------------------------------------------
	always_comb begin
		logic [XW:0] start_x, start_y;
		start_x  = (XW+1)'(pixel_col_q - XW'(off_x_q));
		start_y  = (XW+1)'(pixel_row_q - XW'(off_y_q));
		in_range = (start_x + (XW+1)'(bs_eff) <= (XW+1)'(w_eff)) &&
			(start_y + (XW+1)'(bs_eff) <= (XW+1)'(h_eff));
		emit     = in_range && (BS_W'(off_x_q) + BS_W'(1) >= bs_eff) &&
			(BS_W'(off_y_q) + BS_W'(1) >= bs_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q     <= '0;
			off_y_q     <= '0;
			block_col_q <= '0;
			block_row_q <= '0;
			pixel_col_q <= '0;
			pixel_row_q <= '0;
		end else if (restart) begin
			off_x_q     <= '0;
			off_y_q     <= '0;
			block_col_q <= '0;
			block_row_q <= '0;
			pixel_col_q <= '0;
			pixel_row_q <= '0;
		end else if (acc) begin
			if (pixel_col_q + XW'(1) >= w_eff) begin
				// End of a line; at the end of the frame everything wraps.
				pixel_col_q <= '0;
				off_x_q     <= '0;
				block_col_q <= '0;
				if (pixel_row_q + XW'(1) >= h_eff) begin
					pixel_row_q <= '0;
					off_y_q     <= '0;
					block_row_q <= '0;
				end else begin
					pixel_row_q <= pixel_row_q + XW'(1);
					if (BS_W'(off_y_q) + BS_W'(1) >= bs_eff) begin
						off_y_q     <= '0;
						block_row_q <= block_row_q + XW'(1);
					end else begin
						off_y_q <= off_y_q + OFF_W'(1);
					end
				end
			end else begin
				pixel_col_q <= pixel_col_q + XW'(1);
				if (BS_W'(off_x_q) + BS_W'(1) >= bs_eff) begin
					off_x_q     <= '0;
					block_col_q <= block_col_q + XW'(1);
				end else begin
					off_x_q <= off_x_q + OFF_W'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Column-sum memory. The read is issued as the pixel is taken; the write-back
	// is done from the sum update stage. A read in the same cycle as a write
	// to the same column sees the old entry, so the new sum is bypassed.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (acc && in_range)
			rd_q <= mem[block_col_q[AW-1:0]];
		if (adv && v1_s1)
			mem[addr_s1] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1  <= 1'b0;
			byp_s1 <= 1'b0;
		end else if (adv) begin
			v1_s1  <= acc && in_range;
			byp_s1 <= acc && in_range && v1_s1 && (addr_s1 == block_col_q[AW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1     <= block_col_q[AW-1:0];
			fresh_s1    <= (off_x_q == '0) && (off_y_q == '0);
			emit_s1     <= emit;
			pixel_s1    <= pixels.in_pixel;
			tag_s1      <= '{col: COORD_W'(block_col_q), row: COORD_W'(block_row_q)};
			byp_data_s1 <= wdata;
		end
	end

	// The first pixel of a block loads the entry instead of adding to it.
	always_comb begin
		logic [LANES*SUM_W-1:0] base;
		base = byp_s1 ? byp_data_s1 : rd_q;
		for (int c = 0; c < LANES; c++) begin
			wdata[c*SUM_W +: SUM_W] = (fresh_s1 ? SUM_W'(0) : base[c*SUM_W +: SUM_W]) +
				SUM_W'(pixel_s1[c*CH_W +: CH_W]);
		end
	end

	assign req = '{valid: v1_s1 && emit_s1, sums: wdata, tag: tag_s1};

	bds_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.bs     (bs_eff),
		.req    (req),
		.res    (res)
	);

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res.valid && adv)
			out_valid_q <= 1'b1;
		else if (blocks.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res.valid && adv) begin
			out_pixel_q <= res.pixel;
			out_tag_q   <= res.tag;
		end
	end

	assign blocks.valid     = out_valid_q;
	assign blocks.out_pixel = out_pixel_q;
	assign blocks.out_col   = out_tag_q.col;
	assign blocks.out_row   = out_tag_q.row;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_off_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(BS_W'(off_x_q) < bs_eff) && (BS_W'(off_y_q) < bs_eff))
		else $error("block offset reached the block size");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> pixels.ready)
		else $error("pixels held off with an empty output register");

	a_avg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !adv |=> res.valid && $stable(res.pixel) && $stable(res.tag))
		else $error("averaging result lost during a stall");

	a_bypass_pair: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> v1_s1 && $past(v1_s1))
		else $error("sum bypass without a write in the previous cycle");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for box_downsample_argb_core: streams ARGB frames under many
// block and image sizes, predicts every block average and checks each output.
// Depends on bds_pkg, bds_if and the downsampler RTL.
`default_nettype none

module tb_top;
	import bds_pkg::*;

	// The fourth register index decodes to nothing; writing it must not restart the frame.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam int unsigned RANDOM_ITEMS      = 260;
	// A block's last pixel passes the sum update, multiply and correction stages on its way
	// to the output register. The drain covers work still in flight before a register write.
	localparam int unsigned DRAIN_CYCLES = 8;
	// Roughly a thousand pixels in total. Even under the worst stalls, that stays far below
	// this limit.
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned MAX_REPORTS = 40;

	localparam logic [PIX_W-1:0] EXTREME_PIXELS [8] = '{
		32'h00000000, 32'hFFFFFFFF, 32'hFF000000, 32'h00FF0000,
		32'h0000FF00, 32'h000000FF, 32'hAAAAAAAA, 32'h55555555
	};

	typedef enum {FILL_RANDOM, FILL_ONES, FILL_BINARY, FILL_BRIGHT, FILL_DARK,
		FILL_EXTREMES} fill_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} block_avg_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	bds_pix_if pix_if ();
	bds_blk_if blk_if ();

	box_downsample_argb_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_if),
		.blocks    (blk_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The testbench's own copy of the register file and the frame position. The
	// stimulus process writes it only while the core is idle. Otherwise only the
	// pixel driver touches it, once per accepted transaction.
	logic [BS_W-1:0]  blk_size_reg;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [SUM_W-1:0] lane_sum [MAX_WIDTH_DEF][LANES];
	int unsigned      x_in_blk, y_in_blk, blk_col, blk_row, pix_col, pix_row;

	logic [PIX_W-1:0] pixel_backlog [$];
	block_avg_t       expected_blocks [$];

	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned phase_no       = 0;
	int unsigned mismatches     = 0;
	int unsigned blocks_seen    = 0;
	int unsigned cycle_count    = 0;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void rewind_frame();
		x_in_blk = 0;
		y_in_blk = 0;
		blk_col  = 0;
		blk_row  = 0;
		pix_col  = 0;
		pix_row  = 0;
	endfunction

	// Adds one pixel to its block's column sums. When the pixel closes a complete block,
	// the block's average is queued. Pixels past the last full block column or row only
	// move the counters.
	task automatic accumulate_pixel(input logic [PIX_W-1:0] px);
		int unsigned bsz, wd, ht, area;
		bit          fresh;
		block_avg_t  avg;
		bsz = clamp_dim(blk_size_reg, MAX_BLOCK);
		wd  = clamp_dim(width_reg, MAX_WIDTH_DEF);
		ht  = clamp_dim(height_reg, MAX_WIDTH_DEF);
		if (blk_col < wd / bsz && blk_row < ht / bsz) begin
			// The top-left pixel of a block reloads the entry, so old sums never leak in.
			fresh = (x_in_blk == 0 && y_in_blk == 0);
			for (int c = 0; c < LANES; c++)
				lane_sum[blk_col][c] = (fresh ? SUM_W'(0) : lane_sum[blk_col][c])
					+ SUM_W'(px[(LANES-1-c)*CH_W +: CH_W]);
			if (x_in_blk + 1 >= bsz && y_in_blk + 1 >= bsz) begin
				area = bsz * bsz;
				for (int c = 0; c < LANES; c++)
					avg.pixel[(LANES-1-c)*CH_W +: CH_W] = CH_W'(lane_sum[blk_col][c] / area);
				avg.col = COORD_W'(blk_col);
				avg.row = COORD_W'(blk_row);
				expected_blocks.push_back(avg);
			end
		end
		pix_col++;
		x_in_blk++;
		if (x_in_blk >= bsz) begin
			x_in_blk = 0;
			blk_col++;
		end
		if (pix_col >= wd) begin
			pix_col  = 0;
			x_in_blk = 0;
			blk_col  = 0;
			pix_row++;
			y_in_blk++;
			if (y_in_blk >= bsz) begin
				y_in_blk = 0;
				blk_row++;
			end
			if (pix_row >= ht)
				rewind_frame();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
		input logic [PIX_W-1:0] want);
		if (mismatches < MAX_REPORTS)
			$display("mismatch on %s at output block %0d: got %h, expected %h",
				what, blocks_seen, got, want);
		mismatches++;
	endtask

	// Issues one register write at the next rising edge. It updates the predictor's
	// registers to match. Every decoded index restarts the frame.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_BLOCK_SIZE: begin
				blk_size_reg = data[BS_W-1:0];
				rewind_frame();
			end
			CFG_IMAGE_WIDTH: begin
				width_reg = data;
				rewind_frame();
			end
			CFG_IMAGE_HEIGHT: begin
				height_reg = data;
				rewind_frame();
			end
			default: ;
		endcase
	endtask

	// Writes all three registers in a random order, sometimes mixed with a write to the
	// spare index. Without a restart, only the spare index is written: the frame has to
	// carry on where it stood.
	task automatic set_frame(input bit restart, input logic [DIM_W-1:0] bs_val,
		input logic [DIM_W-1:0] w_val, input logic [DIM_W-1:0] h_val);
		logic [CFG_IDX_W-1:0] order [3];
		logic [DIM_W-1:0]     vals [3];
		int unsigned          first;
		order = '{CFG_BLOCK_SIZE, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT};
		vals  = '{bs_val, w_val, h_val};
		first = $urandom_range(0, 2);
		if (!restart || $urandom_range(0, 7) == 0)
			write_reg(CFG_SPARE, DIM_W'($urandom));
		if (restart)
			for (int k = 0; k < 3; k++)
				write_reg(order[(first + k) % 3], vals[(first + k) % 3]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Queues a batch of pixels under the next idling pattern. It then waits until every
	// pixel has been taken and every expected block has come out, and then lets the
	// pipeline drain.
	task automatic run_pixels(input int unsigned count, input fill_t fill);
		logic [PIX_W-1:0] px;
		@(negedge clk);
		phase_no++;
		case (phase_no % 4)
			0: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct   = 47;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct   = 0;
				sink_stall_pct = 47;
			end
			default: begin
				src_idle_pct   = 33;
				sink_stall_pct = 33;
			end
		endcase
		for (int unsigned i = 0; i < count; i++) begin
			case (fill)
				FILL_ONES:     px = '1;
				FILL_BINARY:   px = $urandom_range(0, 1) ? '1 : '0;
				FILL_EXTREMES: px = EXTREME_PIXELS[i % 8];
				FILL_BRIGHT:
					for (int c = 0; c < LANES; c++)
						px[c*CH_W +: CH_W] = CH_W'($urandom_range(192, 255));
				FILL_DARK:
					for (int c = 0; c < LANES; c++)
						px[c*CH_W +: CH_W] = CH_W'($urandom_range(0, 15));
				default:       px = $urandom;
			endcase
			pixel_backlog.push_back(px);
		end
		while (pixel_backlog.size() != 0 || pix_if.valid || expected_blocks.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Pixel driver. The predictor runs on each accepted transaction. The next pixel goes
	// out as soon as the channel is free, unless the idling pattern holds it back.
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_if.valid    <= 1'b0;
			pix_if.in_pixel <= '0;
		end else begin
			if (pix_if.valid && pix_if.ready)
				accumulate_pixel(pix_if.in_pixel);
			if (!pix_if.valid || pix_if.ready) begin
				if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					pix_if.valid    <= 1'b1;
					pix_if.in_pixel <= pixel_backlog.pop_front();
				end else begin
					pix_if.valid <= 1'b0;
				end
			end
		end
	end

	// Block monitor. Each output transaction is matched against the oldest expected block,
	// field by field. The ready line stalls at random.
	always @(posedge clk) begin : block_check
		block_avg_t want;
		if (!arst_n) begin
			blk_if.ready <= 1'b0;
		end else begin
			if (blk_if.valid && blk_if.ready) begin
				blocks_seen++;
				if (expected_blocks.size() == 0) begin
					report_mismatch("unexpected block", blk_if.out_pixel, '0);
				end else begin
					want = expected_blocks.pop_front();
					if (blk_if.out_pixel !== want.pixel)
						report_mismatch("pixel", blk_if.out_pixel, want.pixel);
					if (blk_if.out_col !== want.col)
						report_mismatch("column", PIX_W'(blk_if.out_col), PIX_W'(want.col));
					if (blk_if.out_row !== want.row)
						report_mismatch("row", PIX_W'(blk_if.out_row), PIX_W'(want.row));
				end
			end
			blk_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Watchdog. A lost block or a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("box_downsample_argb_core test failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned      random_items, bsz, wd, ht, frame, count;
		logic [DIM_W-1:0] bs_val, w_val, h_val;
		fill_t            fill;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_BLOCK_SIZE;
		cfg_data        = '0;
		blk_size_reg    = BLOCK_SIZE_RST;
		width_reg       = IMAGE_WIDTH_RST;
		height_reg      = IMAGE_HEIGHT_RST;
		for (int i = 0; i < MAX_WIDTH_DEF; i++)
			for (int c = 0; c < LANES; c++)
				lane_sum[i][c] = '0;
		rewind_frame();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: 2x2 blocks of a 640-wide image. The first two blocks close early
		// in the second line.
		run_pixels(644, FILL_RANDOM);

		// Directed part. A block size of zero acts as one, and a height of zero acts as
		// one: every pixel is its own block and every line wraps the frame. Then 2x2
		// blocks of a 3x3 image of full-scale pixels. The right column and the bottom row
		// form incomplete blocks and must stay silent. The run goes past the end of the
		// frame into the next one.
		set_frame(1'b1, '0, DIM_W'(3), '0);
		run_pixels(8, FILL_EXTREMES);
		set_frame(1'b1, DIM_W'(2), DIM_W'(3), DIM_W'(3));
		run_pixels(14, FILL_ONES);

		// Widest line: one-pixel blocks with the width written as 4096 or clamped down
		// from a larger value. Only the start of the first line is sent.
		w_val = $urandom_range(0, 1) ? DIM_W'(MAX_WIDTH_DEF) : DIM_W'($urandom_range(4097, 8191));
		set_frame(1'b1, DIM_W'(1), w_val, DIM_W'(2));
		run_pixels(20, FILL_RANDOM);

		// Tallest frame: a one-pixel-wide column with the height written as 4096 or
		// clamped down from a larger value; only its top is sent. The width is written as
		// zero, which acts as one.
		h_val = $urandom_range(0, 1) ? DIM_W'(MAX_WIDTH_DEF) : DIM_W'($urandom_range(4097, 8191));
		set_frame(1'b1, DIM_W'(1), '0, h_val);
		run_pixels(20, FILL_RANDOM);

		// Random part. Most phases use small blocks, with a few at medium sizes, at the largest
		// size or clamped to it. A few phases write only the spare index, so the frame carries on
		// where it stood.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 15))
				0:       bs_val = '0;
				1:       bs_val = DIM_W'(MAX_BLOCK);
				2:       bs_val = DIM_W'($urandom_range(MAX_BLOCK + 1, 31));
				3:       bs_val = DIM_W'($urandom_range(5, MAX_BLOCK - 1));
				default: bs_val = DIM_W'($urandom_range(1, 4));
			endcase
			bsz = clamp_dim(bs_val, MAX_BLOCK);
			if (bsz <= 4) begin
				wd = bsz * $urandom_range(1, 6);
				ht = bsz * $urandom_range(1, 4);
			end else begin
				wd = bsz * $urandom_range(1, 2);
				ht = bsz;
			end
			if ($urandom_range(0, 1))
				wd += $urandom_range(0, bsz - 1);
			if ($urandom_range(0, 1))
				ht += $urandom_range(0, bsz - 1);
			frame = wd * ht;
			count = $urandom_range(frame / 2 + 1, frame + frame / 2);
			if (count > RANDOM_ITEMS - random_items)
				count = RANDOM_ITEMS - random_items;
			// Bits above the block size field are ignored by the core.
			if ($urandom_range(0, 3) == 0)
				bs_val |= DIM_W'($urandom_range(1, 255)) << BS_W;
			w_val = (wd == 1 && $urandom_range(0, 1)) ? '0 : DIM_W'(wd);
			h_val = (ht == 1 && $urandom_range(0, 1)) ? '0 : DIM_W'(ht);
			case ($urandom_range(0, 9))
				0:       fill = FILL_ONES;
				1:       fill = FILL_BINARY;
				2:       fill = FILL_BRIGHT;
				3:       fill = FILL_DARK;
				default: fill = FILL_RANDOM;
			endcase
			set_frame($urandom_range(0, 7) != 0, bs_val, w_val, h_val);
			run_pixels(count, fill);
			random_items += count;
		end

		if (mismatches == 0)
			$display("box_downsample_argb_core test passed");
		else
			$display("box_downsample_argb_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
